@@ sv/ttb_pkg.sv @@
// Shared types and constants for the transparent translated blit.
package ttb_pkg;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_DEST_X          = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEST_Y          = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PIC_WIDTH       = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PIC_HEIGHT      = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH    = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT   = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_TRANSPARENT_KEY = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_TRANSLATE_EN    = 4'd7;

    localparam int unsigned CFG_DATA_W = 11;
    localparam int unsigned ADDR_W     = 20;
    localparam int unsigned PIX_W      = 8;
    localparam int unsigned COL_W      = 11;
    localparam int unsigned ROW_W      = 10;
    localparam int unsigned PROD_W     = 21;

    // Input command codes
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_PIXEL = 1'b1;

    // Current configuration plus the registered origin product
    typedef struct packed {
        logic [9:0]        dest_x;
        logic [9:0]        dest_y;
        logic [10:0]       pic_width;
        logic [9:0]        pic_height;
        logic [10:0]       screen_width;
        logic [9:0]        screen_height;
        logic [7:0]        transparent_key;
        logic              translate_enable;
        logic [PROD_W-1:0] origin_prod;   // dest_y * screen_width
    } cfg_t;

    // Per-pixel results from the address generator
    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic              wr;
        logic              last;
        logic              err;
    } pix_info_t;

endpackage

@@ sv/ttb_cfg_regs.sv @@
// Configuration register file with a registered origin row product.
module ttb_cfg_regs
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                wr_en,
    input  logic [ttb_pkg::CFG_IDX_W-1:0]       wr_index,
    input  logic [ttb_pkg::CFG_DATA_W-1:0]      wr_data,
    output ttb_pkg::cfg_t                       cfg
);

    ttb_pkg::cfg_t cfg_reg;
    ttb_pkg::cfg_t cfg_next;

    // Register writes; the product follows dest_y or screen_width updates
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                ttb_pkg::CFG_DEST_X:
                begin
                    cfg_next.dest_x = wr_data[9:0];
                end
                ttb_pkg::CFG_DEST_Y:
                begin
                    cfg_next.dest_y      = wr_data[9:0];
                    cfg_next.origin_prod = ttb_pkg::PROD_W'(wr_data[9:0] * cfg_reg.screen_width);
                end
                ttb_pkg::CFG_PIC_WIDTH:
                begin
                    cfg_next.pic_width = wr_data[10:0];
                end
                ttb_pkg::CFG_PIC_HEIGHT:
                begin
                    cfg_next.pic_height = wr_data[9:0];
                end
                ttb_pkg::CFG_SCREEN_WIDTH:
                begin
                    cfg_next.screen_width = wr_data[10:0];
                    cfg_next.origin_prod  = ttb_pkg::PROD_W'(cfg_reg.dest_y * wr_data[10:0]);
                end
                ttb_pkg::CFG_SCREEN_HEIGHT:
                begin
                    cfg_next.screen_height = wr_data[9:0];
                end
                ttb_pkg::CFG_TRANSPARENT_KEY:
                begin
                    cfg_next.transparent_key = wr_data[7:0];
                end
                ttb_pkg::CFG_TRANSLATE_EN:
                begin
                    cfg_next.translate_enable = wr_data[0];
                end
                default:
                begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dest_x           <= 10'd0;
            cfg_reg.dest_y           <= 10'd0;
            cfg_reg.pic_width        <= 11'd8;
            cfg_reg.pic_height       <= 10'd8;
            cfg_reg.screen_width     <= 11'd320;
            cfg_reg.screen_height    <= 10'd200;
            cfg_reg.transparent_key  <= 8'd255;
            cfg_reg.translate_enable <= 1'b0;
            cfg_reg.origin_prod      <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ sv/ttb_remap_mem.sv @@
// 256 x 8 translation table memory, one write and one registered read port.
module ttb_remap_mem
(
    input  logic       clk,
    input  logic       wr_en,
    input  logic [7:0] wr_addr,
    input  logic [7:0] wr_data,
    input  logic       rd_en,
    input  logic [7:0] rd_addr,
    output logic [7:0] rd_data
);

    logic [7:0] mem [256];
    logic [7:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ sv/ttb_addr_gen.sv @@
// Column/row counters, fit test, key test and frame-buffer address.
module ttb_addr_gen
#(
    parameter int unsigned MAX_SCREEN_WIDTH  = 1024,
    parameter int unsigned MAX_SCREEN_HEIGHT = 768
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  ttb_pkg::cfg_t                cfg,
    input  logic                         step,
    input  logic [ttb_pkg::PIX_W-1:0]    src_pixel,
    output ttb_pkg::pix_info_t           info
);

    logic [ttb_pkg::COL_W-1:0]  col_reg, col_next;
    logic [ttb_pkg::ROW_W-1:0]  row_reg, row_next;
    logic [ttb_pkg::ADDR_W-1:0] row_base_reg, row_base_next;

    logic                       fits;
    logic [11:0]                x_end;
    logic [10:0]                y_end;
    logic [10:0]                w_eff;
    logic [9:0]                 h_eff;
    logic                       row_end;
    logic                       pic_end;

    // Fit test on the current registers
    always_comb
    begin
        x_end = 12'(cfg.dest_x) + 12'(cfg.pic_width);
        y_end = 11'(cfg.dest_y) + 11'(cfg.pic_height);
        fits  = (cfg.pic_width != '0) && (cfg.pic_height != '0)
             && (32'(cfg.screen_width) <= 32'(MAX_SCREEN_WIDTH))
             && (32'(cfg.screen_height) <= 32'(MAX_SCREEN_HEIGHT))
             && (x_end <= 12'(cfg.screen_width))
             && (y_end <= 11'(cfg.screen_height));
    end

    // End of row / end of picture, zero dimension counts as one
    always_comb
    begin
        w_eff   = (cfg.pic_width == '0) ? 11'd1 : cfg.pic_width;
        h_eff   = (cfg.pic_height == '0) ? 10'd1 : cfg.pic_height;
        row_end = (12'(col_reg) + 12'd1) >= 12'(w_eff);
        pic_end = (11'(row_reg) + 11'd1) >= 11'(h_eff);
    end

    // Result fields for this pixel
    always_comb
    begin
        info.err  = !fits;
        info.last = row_end && pic_end;
        if (!fits)
        begin
            info.addr = '0;
            info.wr   = 1'b0;
        end
        else
        begin
            info.addr = ttb_pkg::ADDR_W'(cfg.origin_prod) + ttb_pkg::ADDR_W'(cfg.dest_x)
                      + row_base_reg + ttb_pkg::ADDR_W'(col_reg);
            info.wr   = (src_pixel != cfg.transparent_key);
        end
    end

    // Counter advance
    always_comb
    begin
        col_next      = col_reg;
        row_next      = row_reg;
        row_base_next = row_base_reg;
        if (step)
        begin
            if (row_end)
            begin
                col_next = '0;
                if (pic_end)
                begin
                    row_next      = '0;
                    row_base_next = '0;
                end
                else
                begin
                    row_next      = row_reg + 1'b1;
                    row_base_next = row_base_reg + ttb_pkg::ADDR_W'(cfg.screen_width);
                end
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            row_base_reg <= '0;
        end
        else
        begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            row_base_reg <= row_base_next;
        end
    end

endmodule

@@ sv/transparent_translated_blit_top.sv @@
// Top level of the transparent translated blit: stream ports and output pipeline.
//
// Usage:
//   s_* carries commands: s_tuser is the command (0 loads a translation
//   entry, 1 delivers a source pixel); s_tdata holds table_index [7:0],
//   table_value [15:8] and src_pixel [23:16]. A load writes the remap table
//   and produces no output transaction; each pixel produces exactly one.
//   m_* carries frame-buffer writes: m_tdata holds dest_address [19:0] and
//   pixel_value [27:20], m_tuser holds write_enable [0] and coord_error [1],
//   and m_tlast marks the last pixel of the picture.
//   cfg_* writes one configuration register per transaction (always ready);
//   users must change registers only with no pixel in flight; not enforced.
// Timing: one transaction per cycle sustained while m_tready stays high. An
//   accepted pixel waits in stage 1 for the synchronous table read, then in
//   the output register, before it appears on m_*.
// Reset: counters clear and the pipeline empties; table contents are not
//   cleared and must be loaded before translated pixels use them.
// Stall: when m_tready is low the output register and the stage behind it
//   hold, and s_tready drops once both are full.
module transparent_translated_blit_top
#(
    parameter int unsigned MAX_SCREEN_WIDTH  = 1024,
    parameter int unsigned MAX_SCREEN_HEIGHT = 768
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    // Command input
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [23:0]                       s_tdata,   // table_index, table_value, src_pixel
    input  logic [0:0]                        s_tuser,   // command
    // Frame-buffer write output
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [31:0]                       m_tdata,   // dest_address, pixel_value, zero pad
    output logic [1:0]                        m_tuser,   // write_enable, coord_error
    output logic                              m_tlast,   // last_pixel
    // Configuration write
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ttb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ttb_pkg::CFG_DATA_W-1:0]    cfg_data
);

    ttb_pkg::cfg_t      cfg;
    ttb_pkg::pix_info_t info;

    logic       in_xact;
    logic       pix_xact;
    logic       load_xact;
    logic [7:0] table_index;
    logic [7:0] table_value;
    logic [7:0] src_pixel;
    logic [7:0] rd_data;

    // Stage 1: waits for the table read
    logic                       s1_valid_reg, s1_valid_next;
    ttb_pkg::pix_info_t         s1_info_reg;
    logic [7:0]                 s1_src_reg;
    logic                       s1_xlate_reg;
    logic                       s1_move;

    // Output register
    logic                       out_valid_reg, out_valid_next;
    logic [31:0]                out_data_reg;
    logic [1:0]                 out_user_reg;
    logic                       out_last_reg;
    logic                       out_free;
    logic [7:0]                 s1_pixel;

    assign cfg_ready = 1'b1;

    // Input field unpacking
    assign table_index = s_tdata[7:0];
    assign table_value = s_tdata[15:8];
    assign src_pixel   = s_tdata[23:16];

    // Flow control
    assign out_free  = !out_valid_reg || m_tready;
    assign s1_move   = s1_valid_reg && out_free;
    assign s_tready  = !s1_valid_reg || out_free;
    assign in_xact   = s_tvalid && s_tready;
    assign pix_xact  = in_xact && (s_tuser[0] == ttb_pkg::CMD_PIXEL);
    assign load_xact = in_xact && (s_tuser[0] == ttb_pkg::CMD_LOAD);

    ttb_cfg_regs u_cfg_regs
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    ttb_addr_gen
    #(
        .MAX_SCREEN_WIDTH  (MAX_SCREEN_WIDTH),
        .MAX_SCREEN_HEIGHT (MAX_SCREEN_HEIGHT)
    )
    u_addr_gen
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .step      (pix_xact),
        .src_pixel (src_pixel),
        .info      (info)
    );

    // Loads and pixel reads never share a cycle, so no forwarding is needed
    ttb_remap_mem u_remap_mem
    (
        .clk     (clk),
        .wr_en   (load_xact),
        .wr_addr (table_index),
        .wr_data (table_value),
        .rd_en   (pix_xact),
        .rd_addr (src_pixel),
        .rd_data (rd_data)
    );

    // Stage 1 control
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_xact)
        begin
            s1_valid_next = pix_xact;
        end
        else if (s1_move)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    // Stage 1 payload
    always_ff @(posedge clk)
    begin
        if (pix_xact)
        begin
            s1_info_reg  <= info;
            s1_src_reg   <= src_pixel;
            s1_xlate_reg <= cfg.translate_enable;
        end
    end

    // Pixel value selection after the table read
    always_comb
    begin
        if (!s1_info_reg.wr)
        begin
            s1_pixel = '0;
        end
        else if (s1_xlate_reg)
        begin
            s1_pixel = rd_data;
        end
        else
        begin
            s1_pixel = s1_src_reg;
        end
    end

    // Output register control
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_move)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            out_data_reg <= {4'b0000, s1_pixel, s1_info_reg.addr};
            out_user_reg <= {s1_info_reg.err, s1_info_reg.wr};
            out_last_reg <= s1_info_reg.last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

endmodule

@@ dv/tb.sv @@
// Self-checking testbench for the transparent translated blit: directed and random pixel streams.
`timescale 1ns / 100ps

module tb;

    localparam int MAX_W       = 1024;
    localparam int MAX_H       = 768;
    localparam int CYCLE_LIMIT = 300000;
    localparam int PRINT_LIMIT = 40;

    // One frame-buffer write as seen on the output stream
    typedef struct {
        logic [ttb_pkg::ADDR_W-1:0] addr;
        logic [ttb_pkg::PIX_W-1:0]  value;
        logic                       wr;
        logic                       last;
        logic                       err;
    } fb_write_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic [0:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [ttb_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [ttb_pkg::CFG_DATA_W-1:0] cfg_data;

    // Shadow registers and blit state, tracked at each accepted transaction
    logic [9:0]                 dst_x     = '0;
    logic [9:0]                 dst_y     = '0;
    logic [10:0]                pic_w     = 11'd8;
    logic [9:0]                 pic_h     = 10'd8;
    logic [10:0]                scr_w     = 11'd320;
    logic [9:0]                 scr_h     = 10'd200;
    logic [7:0]                 trans_key = 8'd255;
    logic                       remap_on  = 1'b0;
    logic [7:0]                 remap_entry [256];
    bit                         entry_loaded [256];
    logic [10:0]                col_cnt   = '0;
    logic [9:0]                 row_cnt   = '0;
    logic [ttb_pkg::ADDR_W-1:0] row_base  = '0;

    fb_write_t pending_writes [$];
    int        mismatch_count = 0;
    int        cycle_count    = 0;
    int        send_idle_pct  = 0;
    int        recv_idle_pct  = 0;

    transparent_translated_blit_top dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        if (mismatch_count < PRINT_LIMIT)
            $display("MISMATCH @%0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    function automatic logic picture_fits();
        int x, y, w, h, sw, sh;
        x  = int'(dst_x);
        y  = int'(dst_y);
        w  = int'(pic_w);
        h  = int'(pic_h);
        sw = int'(scr_w);
        sh = int'(scr_h);
        if (w == 0 || h == 0)
            return 1'b0;
        if (sw > MAX_W || sh > MAX_H)
            return 1'b0;
        if (x + w > sw || y + h > sh)
            return 1'b0;
        return 1'b1;
    endfunction

    // Work out the write for one source byte and advance the picture counters
    task automatic blit_pixel(input logic [7:0] src);
        fb_write_t w;
        int        w_eff;
        int        h_eff;
        w       = '{default: '0};
        w.err   = !picture_fits();
        w_eff   = (pic_w == 0) ? 1 : int'(pic_w);
        h_eff   = (pic_h == 0) ? 1 : int'(pic_h);
        if (!w.err)
        begin
            w.addr = ttb_pkg::ADDR_W'(int'(dst_y) * int'(scr_w) + int'(dst_x)
                                      + int'(row_base) + int'(col_cnt));
            // key is matched on the raw byte, before any remap
            if (src != trans_key)
            begin
                w.wr    = 1'b1;
                w.value = remap_on ? remap_entry[src] : src;
            end
        end
        if (int'(col_cnt) + 1 >= w_eff)
        begin
            col_cnt = '0;
            if (int'(row_cnt) + 1 >= h_eff)
            begin
                row_cnt  = '0;
                row_base = '0;
                w.last   = 1'b1;
            end
            else
            begin
                row_cnt  = row_cnt + 1'b1;
                row_base = row_base + ttb_pkg::ADDR_W'(scr_w);
            end
        end
        else
        begin
            col_cnt = col_cnt + 1'b1;
        end
        pending_writes.push_back(w);
    endtask

    // Output side: random backpressure and per-transaction compare
    always @(posedge clk)
    begin
        fb_write_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_writes.size() == 0)
            begin
                report_mismatch($sformatf("unexpected write addr=%0d value=%0h",
                                          m_tdata[19:0], m_tdata[27:20]));
            end
            else
            begin
                want = pending_writes.pop_front();
                if (m_tdata[19:0] !== want.addr)
                    report_mismatch($sformatf("dest_address got %0d want %0d",
                                              m_tdata[19:0], want.addr));
                if (m_tdata[27:20] !== want.value)
                    report_mismatch($sformatf("pixel_value got %0h want %0h",
                                              m_tdata[27:20], want.value));
                if (m_tuser[0] !== want.wr)
                    report_mismatch($sformatf("write_enable got %b want %b",
                                              m_tuser[0], want.wr));
                if (m_tlast !== want.last)
                    report_mismatch($sformatf("last_pixel got %b want %b",
                                              m_tlast, want.last));
                if (m_tuser[1] !== want.err)
                    report_mismatch($sformatf("coord_error got %b want %b",
                                              m_tuser[1], want.err));
            end
        end
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // One input transaction; the shadow state is updated when it is accepted
    task automatic send_item(input logic cmd, input logic [7:0] idx,
                             input logic [7:0] val, input logic [7:0] pix);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {pix, val, idx};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (cmd == ttb_pkg::CMD_LOAD)
        begin
            remap_entry[idx]  = val;
            entry_loaded[idx] = 1'b1;
        end
        else
        begin
            blit_pixel(pix);
        end
    endtask

    task automatic send_load(input logic [7:0] idx, input logic [7:0] val);
        send_item(ttb_pkg::CMD_LOAD, idx, val, 8'($urandom));
    endtask

    // A pixel that would read a never-loaded entry gets that entry loaded first
    task automatic send_pixel(input logic [7:0] pix);
        if (picture_fits() && remap_on && pix != trans_key && !entry_loaded[pix])
            send_load(pix, 8'($urandom));
        send_item(ttb_pkg::CMD_PIXEL, 8'($urandom), 8'($urandom), pix);
    endtask

    // Stop sending and let every write and any trailing load drain out
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_writes.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Value in the low bits, random junk above the register width
    function automatic logic [ttb_pkg::CFG_DATA_W-1:0] cfg_word(input int value,
                                                                input int width);
        logic [ttb_pkg::CFG_DATA_W-1:0] mask;
        mask = (ttb_pkg::CFG_DATA_W'(1) << width) - ttb_pkg::CFG_DATA_W'(1);
        return (ttb_pkg::CFG_DATA_W'($urandom) & ~mask)
             | (ttb_pkg::CFG_DATA_W'(value) & mask);
    endfunction

    task automatic write_reg(input logic [ttb_pkg::CFG_IDX_W-1:0] idx,
                             input logic [ttb_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            ttb_pkg::CFG_DEST_X:          dst_x     = data[9:0];
            ttb_pkg::CFG_DEST_Y:          dst_y     = data[9:0];
            ttb_pkg::CFG_PIC_WIDTH:       pic_w     = data[10:0];
            ttb_pkg::CFG_PIC_HEIGHT:      pic_h     = data[9:0];
            ttb_pkg::CFG_SCREEN_WIDTH:    scr_w     = data[10:0];
            ttb_pkg::CFG_SCREEN_HEIGHT:   scr_h     = data[9:0];
            ttb_pkg::CFG_TRANSPARENT_KEY: trans_key = data[7:0];
            ttb_pkg::CFG_TRANSLATE_EN:    remap_on  = data[0];
            default: ;
        endcase
    endtask

    // Full register set, written only once the pipeline is empty
    task automatic configure(input int dx, input int dy, input int pw, input int ph,
                             input int sw, input int sh, input int k, input int en);
        wait_idle();
        write_reg(ttb_pkg::CFG_DEST_X,          cfg_word(dx, 10));
        write_reg(ttb_pkg::CFG_DEST_Y,          cfg_word(dy, 10));
        write_reg(ttb_pkg::CFG_PIC_WIDTH,       cfg_word(pw, 11));
        write_reg(ttb_pkg::CFG_PIC_HEIGHT,      cfg_word(ph, 10));
        write_reg(ttb_pkg::CFG_SCREEN_WIDTH,    cfg_word(sw, 11));
        write_reg(ttb_pkg::CFG_SCREEN_HEIGHT,   cfg_word(sh, 10));
        write_reg(ttb_pkg::CFG_TRANSPARENT_KEY, cfg_word(k, 8));
        write_reg(ttb_pkg::CFG_TRANSLATE_EN,    cfg_word(en, 1));
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Reset register values: plain copy, key 255 dropped
    task automatic test_reset_defaults();
        send_pixel(8'h00);
        send_pixel(8'hFF);
        send_pixel(8'h80);
    endtask

    // Bottom-right corner of the largest screen; first pixel ends the old row
    task automatic test_max_address();
        configure(1022, 767, 2, 1, 1024, 768, 0, 0);
        send_pixel(8'hFF);
        send_pixel(8'h00);
        send_pixel(8'hFF);
        send_pixel(8'h7E);
    endtask

    // Remap on; an entry remapping onto the key value is still written
    task automatic test_remap();
        configure(5, 3, 3, 1, 16, 8, 8'h5A, 1);
        send_load(8'h5A, 8'h11);
        send_load(8'hFF, 8'h5A);
        send_load(8'h00, 8'hFF);
        send_pixel(8'h00);
        send_pixel(8'hFF);
        send_pixel(8'h5A);
    endtask

    // Each way the picture can fail to fit, including zero dimensions
    task automatic test_fit_errors();
        configure(10, 0, 8, 1, 17, 8, 0, 1);
        send_pixel(8'($urandom));
        configure(0, 5, 4, 4, 16, 8, 0, 0);
        send_pixel(8'($urandom));
        configure(0, 0, 4, 1, 1025, 8, 0, 1);
        send_pixel(8'($urandom));
        configure(0, 0, 4, 1, 16, 769, 0, 0);
        send_pixel(8'($urandom));
        configure(0, 0, 0, 2, 16, 8, 0, 1);
        send_pixel(8'($urandom));
        send_pixel(8'($urandom));
        configure(0, 0, 2, 0, 16, 8, 0, 0);
        send_pixel(8'($urandom));
        send_pixel(8'($urandom));
    endtask

    // Mostly small fitting pictures, some at the screen limits, some that do not fit
    task automatic random_configure();
        int dx, dy, pw, ph, sw, sh;
        pw = $urandom_range(1, 8);
        ph = $urandom_range(1, 6);
        sw = $urandom_range(0, 1) ? $urandom_range(pw, pw + 8) : $urandom_range(pw, 1024);
        sh = $urandom_range(0, 1) ? $urandom_range(ph, ph + 8) : $urandom_range(ph, 768);
        dx = $urandom_range(0, sw - pw);
        dy = $urandom_range(0, sh - ph);
        case ($urandom_range(0, 9))
            0:
            begin
                case ($urandom_range(0, 6))
                    0: pw = 0;
                    1: ph = 0;
                    2: sw = $urandom_range(1025, 2047);
                    3: sh = $urandom_range(769, 1023);
                    4:
                    begin
                        if (sw - pw + 1 <= 1023)
                            dx = $urandom_range(sw - pw + 1, 1023);
                        else
                        begin
                            dx = 1023;
                            pw = 2;
                        end
                    end
                    5: dy = $urandom_range(sh - ph + 1, 1023);
                    default: pw = $urandom_range(1025, 2047);
                endcase
            end
            1:
            begin
                sw = 1024;
                sh = 768;
                case ($urandom_range(0, 2))
                    0: pw = 1;
                    1: pw = 1024;
                    default: pw = $urandom_range(1, 1024);
                endcase
                case ($urandom_range(0, 2))
                    0: ph = 1;
                    1: ph = 768;
                    default: ph = $urandom_range(1, 8);
                endcase
                dx = 1024 - pw;
                dy = 768 - ph;
            end
            default: ;
        endcase
        configure(dx, dy, pw, ph, sw, sh, $urandom_range(0, 255), $urandom_range(0, 1));
    endtask

    // Random loads and pixels under one idling pattern, new registers per burst
    task automatic test_random_stream(input int send_pct, input int recv_pct, input int items);
        int sent;
        int burst;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        sent = 0;
        while (sent < items)
        begin
            random_configure();
            burst = $urandom_range(15, 90);
            repeat (burst)
            begin
                if ($urandom_range(0, 99) < 12)
                    send_load(8'($urandom), 8'($urandom));
                else if ($urandom_range(0, 99) < 15)
                    send_pixel(trans_key);
                else
                    send_pixel(8'($urandom));
                sent++;
            end
        end
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        m_tready  <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 23;
        recv_idle_pct = 47;
        test_reset_defaults();
        test_max_address();
        test_remap();
        test_fit_errors();

        test_random_stream(23, 47, 583);
        test_random_stream(47, 23, 583);
        test_random_stream(0, 0, 584);

        wait_idle();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
